FILE: sv/ssfs_pkg.sv
// shared types and constants for the sprite sheet frame sequencer
`default_nettype none

package ssfs_pkg;

  localparam int COORD_BITS_DEF    = 8;
  localparam int UV_FRAC_BITS_DEF  = 16;

  localparam int SIZE_W            = 9;
  localparam int CFG_W             = 16;
  localparam int CFG_IDX_W         = 3;
  localparam int ELAPSED_W         = 16;
  localparam int ACCUM_W           = 32;
  localparam int COUNT_W           = 16;
  localparam int DELAY_W           = 16;

  localparam int QUEUE_DEPTH       = 2;
  localparam int NUM_JOBS          = 4;

  localparam logic [SIZE_W-1:0]  SHEET_SIZE_RESET  = SIZE_W'(1);
  localparam logic [COUNT_W-1:0] LOOP_FRAMES_RESET = COUNT_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHEET_ROWS    = 3'd0,
    REG_SHEET_COLUMNS = 3'd1,
    REG_START_ROW     = 3'd2,
    REG_START_COLUMN  = 3'd3,
    REG_LOOP_FRAMES   = 3'd4,
    REG_FRAME_DELAY   = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_RESTART = 1'b1
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [ELAPSED_W-1:0] elapsed;
  } work_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOAD,
    BK_STEP,
    BK_OUT
  } back_state_t;

  typedef enum logic [1:0] {
    JOB_U_LEFT   = 2'd0,
    JOB_V_TOP    = 2'd1,
    JOB_U_RIGHT  = 2'd2,
    JOB_V_BOTTOM = 2'd3
  } uv_job_t;

endpackage

`default_nettype wire

FILE: sv/ssfs_front.sv
// front end: accepts transactions, classifies them and queues them for the back end
`default_nettype none

module ssfs_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_cmd,
  input  wire logic [ssfs_pkg::ELAPSED_W-1:0] in_elapsed,
  output logic                                q_valid,
  input  wire logic                           q_ready,
  output ssfs_pkg::work_t                     q_data
);
  import ssfs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  work_t            mem [QUEUE_DEPTH];
  work_t            push_data;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  // classify: a restart carries no time
  always_comb begin
    push_data.op      = in_cmd ? OP_RESTART : OP_TICK;
    push_data.elapsed = in_cmd ? '0 : in_elapsed;
  end

  assign in_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_data   = mem[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ssfs_back.sv
// back end: config registers, frame state update, serial texture bound divider and result register
`default_nettype none

module ssfs_back #(
  parameter int COORD_BITS   = ssfs_pkg::COORD_BITS_DEF,
  parameter int UV_FRAC_BITS = ssfs_pkg::UV_FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [ssfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ssfs_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                           q_valid,
  output logic                                q_ready,
  input  wire ssfs_pkg::work_t                q_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [COORD_BITS-1:0]               out_cell_row,
  output logic [COORD_BITS-1:0]               out_cell_column,
  output logic [UV_FRAC_BITS:0]               out_u_left,
  output logic [UV_FRAC_BITS:0]               out_v_top,
  output logic [UV_FRAC_BITS:0]               out_u_right,
  output logic [UV_FRAC_BITS:0]               out_v_bottom,
  output logic                                out_advanced
);
  import ssfs_pkg::*;

  localparam int IDX_W     = COORD_BITS + 1;
  localparam int UV_W      = UV_FRAC_BITS + 1;
  localparam int SZ_CMP_W  = (IDX_W > SIZE_W) ? IDX_W : SIZE_W;
  localparam int STEP_W    = $clog2(UV_FRAC_BITS);
  localparam int ACC_SUM_W = ACCUM_W + 1;
  localparam int CNT_INC_W = COUNT_W + 1;

  localparam logic [SZ_CMP_W-1:0] MAX_CELLS_EXT = SZ_CMP_W'(1) << COORD_BITS;
  localparam logic [UV_W-1:0]     UV_ONE        = UV_W'(1) << UV_FRAC_BITS;
  localparam logic [STEP_W-1:0]   LAST_STEP     = STEP_W'(UV_FRAC_BITS - 1);

  // configuration
  logic [SIZE_W-1:0]     sheet_rows_r, sheet_columns_r;
  logic [COORD_BITS-1:0] start_row_r, start_column_r;
  logic [COUNT_W-1:0]    loop_frames_r;
  logic [DELAY_W-1:0]    frame_delay_r;

  // frame state
  back_state_t           state_r, state_nxt;
  logic [ACCUM_W-1:0]    accum_r, accum_nxt;
  logic [COUNT_W-1:0]    frames_r, frames_nxt;
  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic [COORD_BITS-1:0] col_r, col_nxt;
  logic                  adv_r, adv_nxt;

  // divider
  uv_job_t               job_r, job_nxt;
  logic [IDX_W-1:0]      rem_r, rem_nxt;
  logic [UV_FRAC_BITS-1:0] quo_r, quo_nxt;
  logic                  sat_r, sat_nxt;
  logic [STEP_W-1:0]     cnt_r, cnt_nxt;
  logic [UV_W-1:0]       uv_r   [NUM_JOBS];
  logic [UV_W-1:0]       uv_nxt [NUM_JOBS];

  logic [SZ_CMP_W-1:0]   rows_ext, cols_ext;
  logic [IDX_W-1:0]      rows_eff, cols_eff;
  logic [IDX_W-1:0]      row_inc, col_inc;
  logic [CNT_INC_W-1:0]  frames_inc;
  logic                  in_loop;
  logic [COORD_BITS-1:0] step_row, step_col;
  logic [COUNT_W-1:0]    step_frames;
  logic [ACC_SUM_W-1:0]  acc_sum;
  logic [ACCUM_W-1:0]    acc_sat;
  logic                  exceeds;
  logic [IDX_W-1:0]      div_index, div_size;
  logic [IDX_W:0]        rem2, rem_diff;
  logic                  sub_ok;
  logic [UV_FRAC_BITS-1:0] quo_shift;
  logic [UV_W-1:0]       uv_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sheet_rows_r    <= SHEET_SIZE_RESET;
      sheet_columns_r <= SHEET_SIZE_RESET;
      start_row_r     <= '0;
      start_column_r  <= '0;
      loop_frames_r   <= LOOP_FRAMES_RESET;
      frame_delay_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHEET_ROWS: begin
          sheet_rows_r <= cfg_wdata[SIZE_W-1:0];
        end
        REG_SHEET_COLUMNS: begin
          sheet_columns_r <= cfg_wdata[SIZE_W-1:0];
        end
        REG_START_ROW: begin
          start_row_r <= cfg_wdata[COORD_BITS-1:0];
        end
        REG_START_COLUMN: begin
          start_column_r <= cfg_wdata[COORD_BITS-1:0];
        end
        REG_LOOP_FRAMES: begin
          loop_frames_r <= cfg_wdata[COUNT_W-1:0];
        end
        REG_FRAME_DELAY: begin
          frame_delay_r <= cfg_wdata[DELAY_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // effective sheet size: zero acts as one, clamp to the cell range
  always_comb begin
    rows_ext = SZ_CMP_W'(sheet_rows_r);
    cols_ext = SZ_CMP_W'(sheet_columns_r);
    if (rows_ext == '0) begin
      rows_eff = IDX_W'(1);
    end else if (rows_ext > MAX_CELLS_EXT) begin
      rows_eff = MAX_CELLS_EXT[IDX_W-1:0];
    end else begin
      rows_eff = rows_ext[IDX_W-1:0];
    end
    if (cols_ext == '0) begin
      cols_eff = IDX_W'(1);
    end else if (cols_ext > MAX_CELLS_EXT) begin
      cols_eff = MAX_CELLS_EXT[IDX_W-1:0];
    end else begin
      cols_eff = cols_ext[IDX_W-1:0];
    end
  end

  // next frame position
  always_comb begin
    row_inc    = {1'b0, row_r} + IDX_W'(1);
    col_inc    = {1'b0, col_r} + IDX_W'(1);
    frames_inc = {1'b0, frames_r} + CNT_INC_W'(1);
    in_loop    = frames_inc < {1'b0, loop_frames_r};
    if (in_loop) begin
      step_frames = frames_inc[COUNT_W-1:0];
      if (col_inc >= cols_eff) begin
        step_col = '0;
        step_row = (row_inc >= rows_eff) ? '0 : row_inc[COORD_BITS-1:0];
      end else begin
        step_col = col_inc[COORD_BITS-1:0];
        step_row = row_r;
      end
    end else begin
      step_frames = '0;
      step_col    = start_column_r;
      step_row    = start_row_r;
    end
  end

  // saturating time accumulator
  always_comb begin
    acc_sum = {1'b0, accum_r} + ACC_SUM_W'(q_data.elapsed);
    acc_sat = acc_sum[ACCUM_W] ? '1 : acc_sum[ACCUM_W-1:0];
    exceeds = acc_sat > ACCUM_W'(frame_delay_r);
  end

  // restoring divider, one quotient bit a cycle
  always_comb begin
    case (job_r)
      JOB_U_LEFT: begin
        div_index = {1'b0, col_r};
        div_size  = cols_eff;
      end
      JOB_V_TOP: begin
        div_index = {1'b0, row_r};
        div_size  = rows_eff;
      end
      JOB_U_RIGHT: begin
        div_index = col_inc;
        div_size  = cols_eff;
      end
      JOB_V_BOTTOM: begin
        div_index = row_inc;
        div_size  = rows_eff;
      end
      default: begin
        div_index = {1'b0, col_r};
        div_size  = cols_eff;
      end
    endcase
    rem2      = {rem_r, 1'b0};
    sub_ok    = rem2 >= {1'b0, div_size};
    rem_diff  = rem2 - {1'b0, div_size};
    quo_shift = {quo_r[UV_FRAC_BITS-2:0], sub_ok};
    uv_res    = sat_r ? UV_ONE : {1'b0, quo_shift};
  end

  always_comb begin
    state_nxt  = state_r;
    accum_nxt  = accum_r;
    frames_nxt = frames_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    adv_nxt    = adv_r;
    job_nxt    = job_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    sat_nxt    = sat_r;
    cnt_nxt    = cnt_r;
    uv_nxt     = uv_r;
    q_ready    = 1'b0;
    out_valid  = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_ready = 1'b1;
          adv_nxt = 1'b0;
          if (q_data.op == OP_RESTART) begin
            row_nxt    = start_row_r;
            col_nxt    = start_column_r;
            frames_nxt = '0;
          end else if (exceeds) begin
            accum_nxt  = '0;
            row_nxt    = step_row;
            col_nxt    = step_col;
            frames_nxt = step_frames;
            adv_nxt    = 1'b1;
          end else begin
            accum_nxt = acc_sat;
          end
          job_nxt   = JOB_U_LEFT;
          state_nxt = BK_LOAD;
        end
      end
      BK_LOAD: begin
        rem_nxt   = div_index;
        quo_nxt   = '0;
        sat_nxt   = div_index >= div_size;
        cnt_nxt   = '0;
        state_nxt = BK_STEP;
      end
      BK_STEP: begin
        rem_nxt = sub_ok ? rem_diff[IDX_W-1:0] : rem2[IDX_W-1:0];
        quo_nxt = quo_shift;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          uv_nxt[job_r] = uv_res;
          if (job_r == JOB_V_BOTTOM) begin
            state_nxt = BK_OUT;
          end else begin
            job_nxt   = uv_job_t'(job_r + 1'b1);
            state_nxt = BK_LOAD;
          end
        end
      end
      BK_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r  <= '0;
      frames_r <= '0;
      row_r    <= '0;
      col_r    <= '0;
    end else begin
      accum_r  <= accum_nxt;
      frames_r <= frames_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    adv_r <= adv_nxt;
    job_r <= job_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    sat_r <= sat_nxt;
    cnt_r <= cnt_nxt;
    uv_r  <= uv_nxt;
  end

  assign out_cell_row    = row_r;
  assign out_cell_column = col_r;
  assign out_u_left      = uv_r[JOB_U_LEFT];
  assign out_v_top       = uv_r[JOB_V_TOP];
  assign out_u_right     = uv_r[JOB_U_RIGHT];
  assign out_v_bottom    = uv_r[JOB_V_BOTTOM];
  assign out_advanced    = adv_r;

endmodule

`default_nettype wire

FILE: sv/sprite_sheet_frame_sequencer.sv
// top level of the sprite sheet frame sequencer
//
// Steps a cell through a sprite sheet on time ticks and restart commands and
// answers every transaction with the cell and its texture rectangle in
// Q1.UV_FRAC_BITS. For each transaction the back end first updates the frame
// state, then a single shared restoring divider computes the four texture
// bounds one after the other, each with a load step and then one quotient bit
// per cycle, and finally the back end holds the result until it is taken. A
// two-entry queue in front keeps taking transactions meanwhile until it is full.
// Configuration must be written only while the block is idle; the block itself
// does not enforce this.
`default_nettype none

module sprite_sheet_frame_sequencer #(
  parameter int COORD_BITS   = ssfs_pkg::COORD_BITS_DEF,
  parameter int UV_FRAC_BITS = ssfs_pkg::UV_FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [ssfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ssfs_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_cmd,
  input  wire logic [ssfs_pkg::ELAPSED_W-1:0] in_elapsed,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [COORD_BITS-1:0]               out_cell_row,
  output logic [COORD_BITS-1:0]               out_cell_column,
  output logic [UV_FRAC_BITS:0]               out_u_left,
  output logic [UV_FRAC_BITS:0]               out_v_top,
  output logic [UV_FRAC_BITS:0]               out_u_right,
  output logic [UV_FRAC_BITS:0]               out_v_bottom,
  output logic                                out_advanced
);
  import ssfs_pkg::*;

  logic  q_valid;
  logic  q_ready;
  work_t q_data;

  ssfs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_elapsed (in_elapsed),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_data     (q_data)
  );

  ssfs_back #(
    .COORD_BITS   (COORD_BITS),
    .UV_FRAC_BITS (UV_FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_data          (q_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cell_row    (out_cell_row),
    .out_cell_column (out_cell_column),
    .out_u_left      (out_u_left),
    .out_v_top       (out_v_top),
    .out_u_right     (out_u_right),
    .out_v_bottom    (out_v_bottom),
    .out_advanced    (out_advanced)
  );

endmodule

`default_nettype wire

FILE: sv/ssfs_checker.sv
// port level checks for the sprite sheet frame sequencer and their bind
`default_nettype none

module ssfs_checker #(
  parameter int COORD_BITS   = ssfs_pkg::COORD_BITS_DEF,
  parameter int UV_FRAC_BITS = ssfs_pkg::UV_FRAC_BITS_DEF
) (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [COORD_BITS-1:0]   out_cell_row,
  input wire logic [COORD_BITS-1:0]   out_cell_column,
  input wire logic [UV_FRAC_BITS:0]   out_u_left,
  input wire logic [UV_FRAC_BITS:0]   out_v_top,
  input wire logic [UV_FRAC_BITS:0]   out_u_right,
  input wire logic [UV_FRAC_BITS:0]   out_v_bottom,
  input wire logic                    out_advanced
);

  localparam logic [UV_FRAC_BITS:0] UV_ONE = (UV_FRAC_BITS + 1)'(1) << UV_FRAC_BITS;

  a_reset_quiet : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_row)
      && $stable(out_cell_column) && $stable(out_u_left) && $stable(out_v_top)
      && $stable(out_u_right) && $stable(out_v_bottom) && $stable(out_advanced))
    else $error("stalled result changed");

  a_one_result_gap : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("back end produced a result without working on a transaction");

  a_rect_order : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_u_left <= out_u_right && out_v_top <= out_v_bottom)
    else $error("texture rectangle inverted");

  a_rect_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_u_right <= UV_ONE && out_v_bottom <= UV_ONE)
    else $error("texture bound above one");

endmodule

bind sprite_sheet_frame_sequencer ssfs_checker #(
  .COORD_BITS   (COORD_BITS),
  .UV_FRAC_BITS (UV_FRAC_BITS)
) u_ssfs_checker (.*);

`default_nettype wire
